[src/coo_to_csr_builder_assert.svh]
// assertion macros for the csr builder
`ifndef COO_TO_CSR_BUILDER_ASSERT_SVH
`define COO_TO_CSR_BUILDER_ASSERT_SVH
// implication checked every clock, quiet in reset
`define CCB_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// implication checked in the next cycle
`define CCB_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[src/ccb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccb_pkg
// shared types and constants for the csr builder
// ---------------------------------------------------------------------------
package ccb_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int ColDepth    = 2 * MaxEdges;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int CW = $clog2(ColDepth);

  localparam logic [1:0] ActAdd   = 2'd0;
  localparam logic [1:0] ActBuild = 2'd1;
  localparam logic [1:0] ActRow   = 2'd2;
  localparam logic [1:0] ActCol   = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StRange    = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StNotBuilt = 3'd3;
  localparam logic [2:0] StBadIndex = 3'd4;

  localparam logic [0:0] RegVertexCount = 1'd0;
  localparam logic [0:0] RegMirror      = 1'd1;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    OpNone, OpClear, OpCount1, OpCount2, OpScanRd, OpScanWr,
    OpPlace1, OpPlace2, OpPlace3, OpPlace4, OpRead, OpAdd
  } op_t;

  typedef struct packed {
    op_t          op;
    logic         second;   // mirror half of a count or place
    logic [VW:0]  vidx;     // vertex sweep index
    logic [EW:0]  eidx;     // edge sweep index
  } cmd_t;

  typedef struct packed {
    logic [EW:0] edge_count;
    logic        rev;       // stored edge needs its reverse
    logic        skip;      // stored edge out of range
    logic        add_ok;    // add request passes its checks
    logic [VW:0] vc;
  } stat_t;
endpackage

[src/ccb_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccb_datapath
// edge, row start, fill and column memories with the build arithmetic
// ---------------------------------------------------------------------------
module ccb_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  ccb_pkg::cmd_t          cmd,
  input  logic [1:0]             action,
  input  logic [ccb_pkg::VW-1:0] src_vertex,
  input  logic [ccb_pkg::VW-1:0] dst_vertex,
  input  logic [12:0]            read_index,
  input  logic [10:0]            vertex_count,
  input  logic                   mirror_edges,
  input  logic                   built,
  output ccb_pkg::stat_t         stat,
  output logic [13:0]            res_value,
  output logic [2:0]             res_status
);
  import ccb_pkg::*;

  logic [VW-1:0] esrc [MaxEdges];
  logic [VW-1:0] edst [MaxEdges];
  logic [13:0]   rows [MaxVertices+1];
  logic [12:0]   fill [MaxVertices];
  logic [VW-1:0] cols [ColDepth];

  logic [EW:0]   edge_count;
  logic [VW-1:0] eu, ev;
  logic [13:0]   acc, rd_row;
  logic [12:0]   rd_fill;
  logic [VW-1:0] rd_col;
  logic [VW:0]   vc;
  logic [VW-1:0] pu, pv;
  logic [13:0]   pos;

  assign vc = (vertex_count > 11'(MaxVertices)) ? (VW+1)'(MaxVertices)
                                                 : vertex_count[VW:0];
  assign pu = cmd.second ? ev : eu;
  assign pv = cmd.second ? eu : ev;
  assign pos = rd_row + 14'(rd_fill);

  assign stat.edge_count = edge_count;
  assign stat.vc   = vc;
  assign stat.skip = ({1'b0, eu} >= vc) || ({1'b0, ev} >= vc);
  assign stat.rev  = mirror_edges && (eu != ev);
  assign stat.add_ok = (res_status == StOk);

  // edge store and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
    end else if (cmd.op == OpAdd && res_status == StOk && action == ActAdd) begin
      edge_count <= edge_count + 1'b1;
    end
    if (cmd.op == OpAdd && action == ActAdd && {1'b0, src_vertex} < vc &&
        {1'b0, dst_vertex} < vc && edge_count < (EW+1)'(MaxEdges)) begin
      esrc[edge_count[EW-1:0]] <= src_vertex;
      edst[edge_count[EW-1:0]] <= dst_vertex;
    end
    if (cmd.eidx < (EW+1)'(MaxEdges)) begin
      eu <= esrc[cmd.eidx[EW-1:0]];
      ev <= edst[cmd.eidx[EW-1:0]];
    end
  end

  // row / fill tables: one read address per cycle; a clear writes both tables
  always_ff @(posedge clk) begin
    logic [VW:0] ra;
    ra = cmd.vidx;
    unique case (cmd.op)
      OpCount1, OpPlace1: ra = {1'b0, pu} + 1'b1;
      OpPlace2:           ra = {1'b0, pu};
      OpRead:             ra = read_index[VW:0];
      default:            ra = cmd.vidx;
    endcase
    rd_row <= rows[ra];
    rd_fill <= fill[ra[VW-1:0]];
    unique case (cmd.op)
      OpClear: begin
        rows[cmd.vidx] <= '0;
        if (cmd.vidx < (VW+1)'(MaxVertices)) fill[cmd.vidx[VW-1:0]] <= '0;
      end
      OpCount2: rows[{1'b0, pu} + 1'b1] <= rd_row + 1'b1;
      OpScanRd: acc <= '0;
      OpScanWr: begin
        rows[cmd.vidx] <= rd_row + acc;
        acc <= rd_row + acc;
      end
      OpPlace3: begin
        if (pos < 14'(ColDepth)) cols[pos[CW-1:0]] <= pv;
        fill[pu] <= rd_fill + 1'b1;
      end
      default: ;
    endcase
    if (cmd.op == OpRead) rd_col <= cols[read_index[CW-1:0]];
  end

  // result formation for the final cycle of each request
  logic [13:0] total_q;
  always_ff @(posedge clk) begin
    if (cmd.op == OpRead) total_q <= rows[vc];
  end

  always_comb begin
    res_value = '0;
    res_status = StOk;
    unique case (action)
      ActAdd: begin
        if ({1'b0, src_vertex} >= vc || {1'b0, dst_vertex} >= vc)
          res_status = StRange;
        else if (edge_count >= (EW+1)'(MaxEdges)) res_status = StFull;
      end
      ActBuild: res_value = rd_row;
      ActRow: begin
        if (!built) res_status = StNotBuilt;
        else if (read_index > 13'(vc)) res_status = StBadIndex;
        else res_value = rd_row;
      end
      default: begin
        if (!built) res_status = StNotBuilt;
        else if (14'(read_index) >= total_q) res_status = StBadIndex;
        else res_value = 14'(rd_col);
      end
    endcase
  end
endmodule

[src/ccb_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccb_ctrl
// request sequencer for add, build and read
// ---------------------------------------------------------------------------
module ccb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     action,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic           cfg_hit,
  input  ccb_pkg::stat_t stat,
  output ccb_pkg::cmd_t  cmd,
  output logic           built,
  output logic           capture
);
  import ccb_pkg::*;

  typedef enum logic [3:0] {
    Idle, Clr, Cnt0, Cnt1, Cnt2, Scan0, Scan1, Pl0, Pl1, Pl2, Pl3,
    Fin, Rd, Done
  } st_t;
  st_t st;
  logic [1:0] act;

  // build result reads row[vc]: vidx holds vc from the end of placement
  assign in_ready = (st == Idle) && !out_valid;

  // result register loads in the final cycle of a request
  assign capture = (st == Done);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= Idle; out_valid <= 1'b0; built <= 1'b0;
      cmd <= '{op: OpNone, second: 1'b0, vidx: '0, eidx: '0};
      act <= ActAdd;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_hit) built <= 1'b0;
      unique case (st)
        Idle: if (in_valid && in_ready) begin
          act <= action;
          if (action == ActBuild) begin
            st <= Clr; cmd.op <= OpClear; cmd.vidx <= '0;
          end else if (action == ActAdd) begin
            st <= Done; cmd.op <= OpAdd;
          end else begin
            st <= Rd; cmd.op <= OpRead;
          end
        end
        Clr: if (cmd.vidx == (VW+1)'(MaxVertices)) begin
          st <= Cnt0; cmd.op <= OpNone; cmd.eidx <= '0;
        end else cmd.vidx <= cmd.vidx + 1'b1;
        Cnt0: begin  // edge fetch pending
          cmd.second <= 1'b0;
          if (cmd.eidx >= stat.edge_count) begin
            st <= Scan0; cmd.op <= OpScanRd; cmd.vidx <= '0;
          end else begin
            st <= Cnt1; cmd.op <= OpNone;
          end
        end
        Cnt1: if (stat.skip) begin
          cmd.eidx <= cmd.eidx + 1'b1; st <= Cnt0;
        end else begin
          cmd.op <= OpCount1; st <= Cnt2;
        end
        Cnt2: begin
          if (cmd.op == OpCount1) cmd.op <= OpCount2;
          else if (!cmd.second && stat.rev) begin
            cmd.second <= 1'b1; cmd.op <= OpCount1;
          end else begin
            cmd.op <= OpNone; cmd.eidx <= cmd.eidx + 1'b1; st <= Cnt0;
          end
        end
        Scan0: begin  // read row[vidx] for running sum
          cmd.op <= OpNone; st <= Scan1;
        end
        Scan1: begin
          if (cmd.op == OpNone) cmd.op <= OpScanWr;
          else if (cmd.vidx == stat.vc) begin
            cmd.op <= OpNone; cmd.eidx <= '0; st <= Pl0;
          end else begin
            cmd.op <= OpNone; cmd.vidx <= cmd.vidx + 1'b1; st <= Scan0;
          end
        end
        Pl0: begin
          cmd.second <= 1'b0;
          if (cmd.eidx >= stat.edge_count) begin
            st <= Fin; cmd.vidx <= stat.vc;
          end else st <= Pl1;
        end
        Pl1: if (stat.skip) begin
          cmd.eidx <= cmd.eidx + 1'b1; st <= Pl0;
        end else begin
          cmd.op <= OpPlace2; st <= Pl2;
        end
        Pl2: begin cmd.op <= OpPlace3; st <= Pl3; end
        Pl3: begin
          if (!cmd.second && stat.rev) begin
            cmd.second <= 1'b1; cmd.op <= OpPlace2; st <= Pl2;
          end else begin
            cmd.op <= OpNone; cmd.eidx <= cmd.eidx + 1'b1; st <= Pl0;
          end
        end
        Fin: begin
          built <= 1'b1; st <= Done; cmd.op <= OpNone;
        end
        Rd: begin cmd.op <= OpNone; st <= Done; end
        Done: begin
          cmd.op <= OpNone;
          out_valid <= 1'b1; st <= Idle;
          // a stored edge invalidates the built table
          if (act == ActAdd && stat.add_ok) built <= 1'b0;
        end
        default: st <= Idle;
      endcase
    end
  end
endmodule

[src/coo_to_csr_builder.sv]
`timescale 1ns / 1ps
// an add answers through the Done state, a read through Rd and then Done; the
// next request is accepted the cycle after the result is taken
// a build clears the tables, counts each in-range stored edge and its mirror,
// scans the rows into a running sum, then places them; one request is in
// flight and the input waits while a result is held; synchronous reset clears
// counts, flags, state and config; result and memories are not swept
// ---------------------------------------------------------------------------
// coo_to_csr_builder
// sparse row adjacency builder top level
// ---------------------------------------------------------------------------
module coo_to_csr_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [9:0]  src_vertex,
  input  logic [9:0]  dst_vertex,
  input  logic [12:0] read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] read_value,
  output logic [2:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import ccb_pkg::*;
  `include "coo_to_csr_builder_assert.svh"

  logic [10:0] vertex_count;
  logic        mirror_edges;
  logic        built, capture;
  cmd_t        cmd;
  stat_t       stat;
  logic [13:0] res_value;
  logic [2:0]  res_status;
  logic [1:0]  act_q;
  logic [9:0]  src_q, dst_q;
  logic [12:0] idx_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 11'd1024; mirror_edges <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == RegVertexCount) vertex_count <= cfg_data;
      else mirror_edges <= cfg_data[0];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_q <= action; src_q <= src_vertex; dst_q <= dst_vertex;
      idx_q <= read_index;
    end
  end

  ccb_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .action, .out_valid, .out_ready,
    .cfg_hit(cfg_write), .stat, .cmd, .built, .capture
  );

  ccb_datapath u_dp (
    .clk, .rst, .cmd, .action(act_q), .src_vertex(src_q), .dst_vertex(dst_q),
    .read_index(idx_q), .vertex_count, .mirror_edges, .built, .stat,
    .res_value, .res_status
  );

  // result register
  always_ff @(posedge clk) begin
    if (capture) begin
      read_value <= res_value; status <= res_status;
    end
  end

  `CCB_ASSERT_IMP(a_no_accept_busy, out_valid, !in_ready)
  `CCB_ASSERT_NEXT(a_capture_valid, capture, out_valid)
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coo_to_csr_builder testbench
// Drives edge, build and read requests through the valid/ready channels. A
// behavioral copy of the sparse row builder predicts every response, which is
// then compared field by field. Registers are rewritten between phases. A
// last phase runs with no idling.
// ---------------------------------------------------------------------------
module testbench;
  import ccb_pkg::*;

  localparam int   CycleLimit = 5000000;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  src;
    logic [9:0]  dst;
    logic [12:0] index;
  } request_t;

  typedef struct packed {
    logic [13:0] value;
    logic [2:0]  status;
  } response_t;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [1:0]  action;
  logic [9:0]  src_vertex, dst_vertex;
  logic [12:0] read_index;
  logic        out_valid, out_ready;
  logic [13:0] read_value;
  logic [2:0]  status;
  logic        cfg_write;
  logic        cfg_index;
  logic [10:0] cfg_data;

  coo_to_csr_builder dut (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioral copy of the builder state
  int unsigned vert_reg;
  bit          mirror_reg;
  int unsigned edge_src_mem [MaxEdges];
  int unsigned edge_dst_mem [MaxEdges];
  int unsigned row_start [MaxVertices + 1];
  int unsigned fill_ofs [MaxVertices];
  int unsigned column_mem [ColDepth];
  int unsigned edge_total;
  int unsigned entry_total;
  bit          csr_ready;

  request_t  pending_reqs[$];
  response_t expected_resp[$];
  int        mismatches, n_requests, n_builds, n_responses, n_full;
  int        n_queued;
  int        cycles;
  bit        quiet;
  bit        req_taken;
  int        send_gap, recv_stall;

  function automatic int unsigned live_vertices();
    return (vert_reg > MaxVertices) ? MaxVertices : vert_reg;
  endfunction

  function automatic void place_entry(int unsigned u, int unsigned v);
    int unsigned pos;
    pos = row_start[u] + fill_ofs[u];
    if (pos < ColDepth) column_mem[pos] = v;
    fill_ofs[u]++;
  endfunction

  // recount degrees, prefix sum and scatter neighbours
  function automatic int unsigned rebuild_rows();
    int unsigned vc, u, v;
    vc = live_vertices();
    for (int i = 0; i <= MaxVertices; i++) row_start[i] = 0;
    for (int i = 0; i < MaxVertices; i++) fill_ofs[i] = 0;
    for (int i = 0; i < edge_total; i++) begin
      u = edge_src_mem[i];
      v = edge_dst_mem[i];
      if (u < vc && v < vc) begin
        row_start[u + 1]++;
        if (mirror_reg && u != v) row_start[v + 1]++;
      end
    end
    for (int i = 0; i < vc; i++) row_start[i + 1] += row_start[i];
    for (int i = 0; i < edge_total; i++) begin
      u = edge_src_mem[i];
      v = edge_dst_mem[i];
      if (u < vc && v < vc) begin
        place_entry(u, v);
        if (mirror_reg && u != v) place_entry(v, u);
      end
    end
    csr_ready = 1'b1;
    return row_start[vc];
  endfunction

  // apply one accepted request and queue its response
  function automatic void predict_response(request_t r);
    response_t   e;
    int unsigned vc;
    vc = live_vertices();
    e.value = '0;
    e.status = StOk;
    case (r.action)
      ActAdd: begin
        if (r.src >= vc || r.dst >= vc) e.status = StRange;
        else if (edge_total >= MaxEdges) e.status = StFull;
        else begin
          edge_src_mem[edge_total] = r.src;
          edge_dst_mem[edge_total] = r.dst;
          edge_total++;
          csr_ready = 1'b0;
        end
      end
      ActBuild: begin
        entry_total = rebuild_rows();
        e.value = entry_total[13:0];
        n_builds++;
      end
      default: begin
        if (!csr_ready) e.status = StNotBuilt;
        else if (r.action == ActRow) begin
          if (r.index > vc) e.status = StBadIndex;
          else e.value = row_start[r.index][13:0];
        end else begin
          if (r.index >= row_start[vc] || r.index >= ColDepth) e.status = StBadIndex;
          else e.value = column_mem[r.index][13:0];
        end
      end
    endcase
    if (e.status == StFull) n_full++;
    expected_resp.push_back(e);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      req_taken <= 1'b0;
    end else if (!(in_valid && !req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        req_taken <= 1'b0;
        action <= pending_reqs[0].action;
        src_vertex <= pending_reqs[0].src;
        dst_vertex <= pending_reqs[0].dst;
        read_index <= pending_reqs[0].index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // response stalls
  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: request acceptance and response check
  always @(posedge clk) begin
    if (!rst) begin
      cycles++;
      if (in_valid && in_ready && !req_taken) begin
        predict_response(pending_reqs.pop_front());
        req_taken <= 1'b1;
        n_requests++;
      end
      if (out_valid && out_ready) begin
        n_responses++;
        if (expected_resp.size() == 0) begin
          $display("unexpected response at %0t", $realtime);
          mismatches++;
        end else begin
          response_t e;
          e = expected_resp.pop_front();
          if (read_value !== e.value) report_mismatch("read_value", read_value, e.value);
          if (status !== e.status) report_mismatch("status", status, e.status);
        end
      end
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_req(input logic [1:0] a, input int s, input int d, input int i);
    request_t r;
    r.action = a;
    r.src = s[9:0];
    r.dst = d[9:0];
    r.index = i[12:0];
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_resp.size() > 0 || in_valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input int data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[10:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == RegVertexCount) vert_reg = data[10:0];
    else mirror_reg = data[0];
    csr_ready = 1'b0;
  endtask

  // random vertex, mostly inside the live range
  function automatic int pick_vertex();
    int unsigned vc;
    vc = live_vertices();
    if (vc == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, vc - 1);
  endfunction

  task automatic queue_reads(input int n);
    int unsigned vc;
    vc = live_vertices();
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0: queue_req(ActRow, $urandom, $urandom, $urandom_range(0, 8191));
        1: queue_req(ActCol, $urandom, $urandom, $urandom_range(0, 8191));
        2, 3: queue_req(ActRow, $urandom, $urandom, $urandom_range(0, vc + 1));
        default: queue_req(ActCol, $urandom, $urandom, $urandom_range(0, entry_total));
      endcase
    end
  endtask

  // stimulus
  initial begin
    int vc_choices[8] = '{0, 1, 2, 3, 16, 100, 1024, 2047};
    bit first_pass;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    action = '0;
    src_vertex = '0;
    dst_vertex = '0;
    read_index = '0;
    cfg_write = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    vert_reg = 1024;
    mirror_reg = 1'b1;
    edge_total = 0;
    entry_total = 0;
    csr_ready = 1'b0;
    n_queued = 0;
    for (int i = 0; i <= MaxVertices; i++) row_start[i] = 0;
    for (int i = 0; i < MaxVertices; i++) fill_ofs[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reads before any build, then a small graph at reset settings
    queue_req(ActRow, 0, 0, 0);
    queue_req(ActCol, 0, 0, 0);
    queue_req(ActAdd, 0, 0, 0);
    queue_req(ActAdd, 1023, 0, 0);
    queue_req(ActAdd, 5, 7, 0);
    queue_req(ActAdd, 5, 7, 0);
    queue_req(ActAdd, 7, 1023, 0);
    queue_req(ActBuild, 0, 0, 0);
    queue_req(ActRow, 0, 0, 1);
    queue_req(ActRow, 0, 0, 1024);
    queue_req(ActRow, 0, 0, 1025);
    queue_req(ActRow, 0, 0, 8191);
    for (int i = 0; i <= 9; i++) queue_req(ActCol, 0, 0, i);
    queue_req(ActCol, 0, 0, 8191);
    // add after build drops the built state
    queue_req(ActAdd, 3, 3, 0);
    queue_req(ActCol, 0, 0, 0);
    wait_idle();

    // tiny graph, no mirroring: out-of-range adds and skipped stored edges
    set_reg(RegVertexCount, 8);
    set_reg(RegMirror, 0);
    queue_req(ActAdd, 9, 1, 0);
    queue_req(ActAdd, 1, 1023, 0);
    queue_req(ActAdd, 2, 6, 0);
    queue_req(ActBuild, 0, 0, 0);
    queue_req(ActRow, 0, 0, 8);
    queue_req(ActRow, 0, 0, 9);
    queue_req(ActCol, 0, 0, 0);
    wait_idle();

    // zero vertices
    set_reg(RegVertexCount, 0);
    queue_req(ActAdd, 0, 0, 0);
    queue_req(ActBuild, 0, 0, 0);
    queue_req(ActRow, 0, 0, 0);
    queue_req(ActCol, 0, 0, 0);
    wait_idle();

    // random phases: adds, build, then reads against the fresh table
    first_pass = 1'b1;
    while (n_queued < 1700) begin
      set_reg(RegVertexCount, first_pass ? 2047 : vc_choices[$urandom_range(0, 7)]);
      first_pass = 1'b0;
      set_reg(RegMirror, $urandom_range(0, 1));
      for (int c = 0; c < 12 && n_queued < 1700; c++) begin
        int n_add;
        quiet = ($urandom_range(0, 3) == 0);
        n_add = $urandom_range(1, 6);
        for (int k = 0; k < n_add; k++) queue_req(ActAdd, pick_vertex(), pick_vertex(), 0);
        queue_req(ActBuild, 0, 0, 0);
        wait_idle();
        queue_reads($urandom_range(6, 12));
        if ($urandom_range(0, 4) == 0) begin
          queue_req(ActAdd, pick_vertex(), pick_vertex(), 0);
          queue_reads(2);
        end
        if ($urandom_range(0, 6) == 0) queue_req(ActBuild, 0, 0, 0);
        wait_idle();
      end
    end

    // last phase, no idling: smaller vertex range with an out-of-range add
    quiet = 1'b1;
    set_reg(RegVertexCount, 600);
    set_reg(RegMirror, 1);
    queue_req(ActAdd, 700, 1, 0);
    queue_req(ActAdd, 1, 2, 0);
    for (int k = 0; k < 20; k++) queue_req(ActAdd, pick_vertex(), pick_vertex(), 0);
    queue_req(ActBuild, 0, 0, 0);
    wait_idle();
    queue_reads(40);
    wait_idle();

    repeat (20) @(posedge clk);
    $display("requests %0d, responses %0d, builds %0d, store-full answers %0d",
             n_requests, n_responses, n_builds, n_full);
    $display("covered adds, builds, row and column reads over several register settings");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
